// File: rtl/asof_join_scan_macros.svh
// assertion macros for the as-of join scan checker
`ifndef ASOF_JOIN_SCAN_MACROS_SVH
`define ASOF_JOIN_SCAN_MACROS_SVH

// same-cycle implication
`define AJS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asof_join_scan same-cycle check failed");

// next-cycle implication
`define AJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asof_join_scan next-cycle check failed");

`endif

// File: rtl/ajs_pkg.sv
// types and constants for the as-of join scan block
package ajs_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned PROD_W  = 64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] ts;
    logic [QTY_W-1:0]  price;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/ajs_ram.sv
// generic single-port-write, registered-read ram
module ajs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/asof_join_scan.sv
// as-of join scan top level: price table in ram, linear scan per query
// A load transaction (in_opcode 0) appends one price entry and never raises
// busy; once ENTRIES entries are stored further loads are dropped.
// A query transaction (in_opcode 1) reads every stored entry from the one ram
// read port, one entry per cycle; busy stays high through the scan and the
// multiply, and also through the emit state when a match is found. The
// match is shown on the out_ ports for exactly one cycle with out_valid high, in
// the last busy cycle; the receiver cannot stall it and must take it then.
module asof_join_scan
  import ajs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic [KEY_W-1:0]  in_stock_key,
  input  logic [TIME_W-1:0] in_time_stamp,
  input  logic [QTY_W-1:0]  in_quantity,
  output logic              out_valid,
  output logic [KEY_W-1:0]  out_match_key,
  output logic [TIME_W-1:0] out_price_time,
  output logic [QTY_W-1:0]  out_matched_price,
  output logic [TIME_W-1:0] out_order_time,
  output logic [QTY_W-1:0]  out_order_amount,
  output logic [PROD_W-1:0] out_total_value
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic              rd_vld_r;
  logic              found_r;
  logic [KEY_W-1:0]  q_key_r;
  logic [TIME_W-1:0] q_time_r;
  logic [QTY_W-1:0]  q_qty_r;
  logic [TIME_W-1:0] best_time_r;
  logic [QTY_W-1:0]  best_price_r;
  logic [PROD_W-1:0] prod_r;

  logic   accept;
  logic   do_load;
  logic   do_query;
  logic   rd_en;
  logic   hit;
  entry_t wr_entry;
  entry_t rd_entry;
  logic [ENTRY_W-1:0] rd_data;

  assign accept   = start && !busy;
  assign do_load  = accept && (opcode_t'(in_opcode) == OP_LOAD) &&
                    (count_r < CNT_W'(ENTRIES));
  assign do_query = accept && (opcode_t'(in_opcode) == OP_QUERY);

  assign wr_entry = '{key: in_stock_key, ts: in_time_stamp, price: in_quantity};
  assign rd_entry = entry_t'(rd_data);

  ajs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_query) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!(idx_r < count_r)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = found_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: rd_en = (idx_r < count_r);
      ST_MUL:  busy = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  assign hit = rd_vld_r && (rd_entry.key == q_key_r) && (rd_entry.ts <= q_time_r) &&
               (!found_r || (rd_entry.ts > best_time_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (do_load) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (do_query) begin
        idx_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (rd_en) idx_r <= idx_r + CNT_W'(1);
        if (hit) found_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (do_query) begin
      q_key_r  <= in_stock_key;
      q_time_r <= in_time_stamp;
      q_qty_r  <= in_quantity;
    end
    if (hit) begin
      best_time_r  <= rd_entry.ts;
      best_price_r <= rd_entry.price;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(best_price_r) * PROD_W'(q_qty_r);
    end
  end

  assign out_match_key     = q_key_r;
  assign out_price_time    = best_time_r;
  assign out_matched_price = best_price_r;
  assign out_order_time    = q_time_r;
  assign out_order_amount  = q_qty_r;
  assign out_total_value   = prod_r;

endmodule

// File: rtl/ajs_checker.sv
// port-level checker for the as-of join scan block, with its bind
`include "asof_join_scan_macros.svh"

module ajs_checker
  import ajs_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              in_opcode,
  input logic              out_valid,
  input logic [TIME_W-1:0] out_price_time,
  input logic [TIME_W-1:0] out_order_time
);

  logic load_acc;
  logic query_acc;

  assign load_acc  = start && !busy && (opcode_t'(in_opcode) == OP_LOAD);
  assign query_acc = start && !busy && (opcode_t'(in_opcode) == OP_QUERY);

  `AJS_ASSERT_NOW(a_result_while_busy, clk, rst_n, out_valid, busy)
  `AJS_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid && !busy)
  `AJS_ASSERT_NEXT(a_query_goes_busy, clk, rst_n, query_acc, busy && !out_valid)
  `AJS_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, load_acc, !busy && !out_valid)
  `AJS_ASSERT_NOW(a_match_not_later, clk, rst_n, out_valid, out_price_time <= out_order_time)

endmodule

bind asof_join_scan ajs_checker u_ajs_checker (.*);

// File: tb/asof_join_scan_checker.sv
// checker for the as-of join scan: predicts each join from its own price table and compares
`timescale 1ns / 1ps
module asof_join_scan_checker
  import ajs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_opcode,
  input  logic [KEY_W-1:0]  in_stock_key,
  input  logic [TIME_W-1:0] in_time_stamp,
  input  logic [QTY_W-1:0]  in_quantity,
  input  logic              out_valid,
  input  logic [KEY_W-1:0]  out_match_key,
  input  logic [TIME_W-1:0] out_price_time,
  input  logic [QTY_W-1:0]  out_matched_price,
  input  logic [TIME_W-1:0] out_order_time,
  input  logic [QTY_W-1:0]  out_order_amount,
  input  logic [PROD_W-1:0] out_total_value,
  output int unsigned       fail_count,
  output int unsigned       open_rows,
  output int unsigned       match_count,
  output int unsigned       drop_count
);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] price_ts;
    logic [QTY_W-1:0]  price;
    logic [TIME_W-1:0] order_ts;
    logic [QTY_W-1:0]  amount;
    logic [PROD_W-1:0] value;
  } join_row_t;

  logic [KEY_W-1:0]  key_tab   [ENTRIES];
  logic [TIME_W-1:0] time_tab  [ENTRIES];
  logic [QTY_W-1:0]  price_tab [ENTRIES];
  int unsigned       table_rows;
  join_row_t         due_rows [$];
  join_row_t         got_row;

  initial begin
    fail_count  = 0;
    open_rows   = 0;
    match_count = 0;
    drop_count  = 0;
    table_rows  = 0;
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic absorb(input opcode_t op, input logic [KEY_W-1:0] key,
                        input logic [TIME_W-1:0] ts, input logic [QTY_W-1:0] qty);
    logic              hit;
    int unsigned       best;
    logic [TIME_W-1:0] best_ts;
    join_row_t         row;
    if (op == OP_LOAD) begin
      if (table_rows < ENTRIES) begin
        key_tab[table_rows]   = key;
        time_tab[table_rows]  = ts;
        price_tab[table_rows] = qty;
        table_rows++;
      end else begin
        drop_count++;
      end
    end else begin
      hit     = 1'b0;
      best    = 0;
      best_ts = '0;
      // strict compare keeps the earliest loaded entry on equal timestamps
      for (int unsigned i = 0; i < table_rows; i++) begin
        if (key_tab[i] == key && time_tab[i] <= ts && (!hit || time_tab[i] > best_ts)) begin
          hit     = 1'b1;
          best    = i;
          best_ts = time_tab[i];
        end
      end
      if (hit) begin
        row.key      = key;
        row.price_ts = best_ts;
        row.price    = price_tab[best];
        row.order_ts = ts;
        row.amount   = qty;
        row.value    = {32'b0, price_tab[best]} * {32'b0, qty};
        due_rows.insert(due_rows.size(), row);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (due_rows.size() == 0) begin
          $error("result with no pending join: key %0h, order time %0h",
                 out_match_key, out_order_time);
          fail_count++;
        end else begin
          got_row = due_rows.pop_front();
          match_count++;
          check_field("match_key", got_row.key, out_match_key);
          check_field("price_time", got_row.price_ts, out_price_time);
          check_field("matched_price", got_row.price, out_matched_price);
          check_field("order_time", got_row.order_ts, out_order_time);
          check_field("order_amount", got_row.amount, out_order_amount);
          check_field("total_value", got_row.value, out_total_value);
        end
      end
      if (start && !busy)
        absorb(opcode_t'(in_opcode), in_stock_key, in_time_stamp, in_quantity);
      open_rows <= due_rows.size();
    end
  end

endmodule

// File: tb/tb_asof_join_scan.sv
// testbench top for the as-of join scan: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module tb_asof_join_scan;
  import ajs_pkg::*;

  localparam logic [KEY_W-1:0]  KEY_A    = 64'h0123_4567_89AB_CDEF;
  localparam logic [KEY_W-1:0]  KEY_B    = 64'hFEDC_BA98_7654_3210;
  localparam logic [KEY_W-1:0]  KEY_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [QTY_W-1:0]  QTY_MAX  = '1;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  opcode_t           in_opcode;
  logic [KEY_W-1:0]  in_stock_key;
  logic [TIME_W-1:0] in_time_stamp;
  logic [QTY_W-1:0]  in_quantity;
  logic              out_valid;
  logic [KEY_W-1:0]  out_match_key;
  logic [TIME_W-1:0] out_price_time;
  logic [QTY_W-1:0]  out_matched_price;
  logic [TIME_W-1:0] out_order_time;
  logic [QTY_W-1:0]  out_order_amount;
  logic [PROD_W-1:0] out_total_value;

  int unsigned fail_count;
  int unsigned open_rows;
  int unsigned match_count;
  int unsigned drop_count;
  int unsigned burst_left;
  int unsigned load_total;
  int unsigned query_total;
  int unsigned stored;
  logic [KEY_W-1:0] key_pool [8];

  asof_join_scan dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_stock_key     (in_stock_key),
    .in_time_stamp    (in_time_stamp),
    .in_quantity      (in_quantity),
    .out_valid        (out_valid),
    .out_match_key    (out_match_key),
    .out_price_time   (out_price_time),
    .out_matched_price(out_matched_price),
    .out_order_time   (out_order_time),
    .out_order_amount (out_order_amount),
    .out_total_value  (out_total_value)
  );

  asof_join_scan_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_stock_key     (in_stock_key),
    .in_time_stamp    (in_time_stamp),
    .in_quantity      (in_quantity),
    .out_valid        (out_valid),
    .out_match_key    (out_match_key),
    .out_price_time   (out_price_time),
    .out_matched_price(out_matched_price),
    .out_order_time   (out_order_time),
    .out_order_amount (out_order_amount),
    .out_total_value  (out_total_value),
    .fail_count       (fail_count),
    .open_rows        (open_rows),
    .match_count      (match_count),
    .drop_count       (drop_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #(70_000_000);
    $display("** asof_join_scan: FAILED **");
    $finish;
  end

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 85)
      return key_pool[3'($urandom_range(7))];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned r;
    logic [63:0] wide;
    r    = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (r < 5)
      return '0;
    if (r < 10)
      return TIME_MAX;
    if (r < 20)
      return wide[TIME_W-1:0];
    return TIME_W'($urandom_range(0, 400));
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    if (r < 16)
      return QTY_MAX;
    return $urandom;
  endfunction

  // bursts of back-to-back transactions separated by random gaps
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(input opcode_t op, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] ts, input logic [QTY_W-1:0] qty);
    start         <= 1'b1;
    in_opcode     <= op;
    in_stock_key  <= key;
    in_time_stamp <= ts;
    in_quantity   <= qty;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      load_total++;
      if (stored < ENTRIES)
        stored++;
    end else begin
      query_total++;
    end
    pace();
  endtask

  task automatic send_random(input int unsigned query_pct);
    opcode_t op;
    op = ($urandom_range(99) < query_pct) ? OP_QUERY : OP_LOAD;
    send_item(op, pick_key(), pick_time(), pick_qty());
  endtask

  // hold the sender until the block is idle and no join is outstanding
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || open_rows != 0) @(posedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_LOAD;
    in_stock_key  = '0;
    in_time_stamp = '0;
    in_quantity   = '0;
    burst_left    = 0;
    load_total    = 0;
    query_total   = 0;
    stored        = 0;
    key_pool[0]   = '0;
    key_pool[1]   = KEY_MAX;
    key_pool[2]   = 64'hAAAA_AAAA_AAAA_AAAA;
    key_pool[3]   = 64'h5555_5555_5555_5555;
    key_pool[4]   = KEY_A;
    for (int i = 5; i < 8; i++)
      key_pool[i] = {$urandom, $urandom};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, ties, all-later entries, absent key and the extremes
    send_item(OP_QUERY, KEY_A, TIME_MAX, QTY_MAX);
    send_item(OP_LOAD,  KEY_A, 48'd100, 32'd7);
    send_item(OP_LOAD,  KEY_A, 48'd100, 32'd9);
    send_item(OP_LOAD,  KEY_A, 48'd50, 32'd3);
    send_item(OP_LOAD,  KEY_A, 48'd200, QTY_MAX);
    send_item(OP_LOAD,  '0, '0, '0);
    send_item(OP_LOAD,  KEY_MAX, TIME_MAX, QTY_MAX);
    send_item(OP_LOAD,  64'hAAAA_AAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_item(OP_LOAD,  64'h5555_5555_5555_5555, 48'h5555_5555_5555, 32'h5555_5555);
    send_item(OP_QUERY, KEY_A, 48'd99, 32'd11);
    send_item(OP_QUERY, KEY_A, 48'd100, 32'd2);
    send_item(OP_QUERY, KEY_A, 48'd49, 32'd5);
    send_item(OP_QUERY, KEY_A, TIME_MAX, QTY_MAX);
    send_item(OP_QUERY, KEY_A, 48'd150, '0);
    send_item(OP_QUERY, KEY_B, TIME_MAX, 32'd1);
    send_item(OP_QUERY, '0, '0, QTY_MAX);
    send_item(OP_QUERY, KEY_MAX, TIME_MAX, QTY_MAX);
    send_item(OP_QUERY, KEY_MAX, TIME_MAX - 48'd1, QTY_MAX);
    send_item(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    send_item(OP_QUERY, 64'h5555_5555_5555_5555, TIME_MAX, 32'hAAAA_AAAA);
    drain();

    repeat (300) send_random(40);
    // short evenly mixed stretch
    repeat (16) send_random(50);
    drain();
    repeat (250) send_random(65);

    drain();
    repeat (ENTRIES + 10) @(posedge clk);
    $display("covered %0d loads (%0d dropped with the table full) and %0d queries",
             load_total, drop_count, query_total);
    $display("%0d queries matched and were checked field by field", match_count);
    if (fail_count == 0) begin
      $display("** asof_join_scan: PASSED **");
    end else begin
      $display("** asof_join_scan: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ajs_pkg.sv
rtl/ajs_ram.sv
rtl/asof_join_scan.sv
rtl/ajs_checker.sv
tb/asof_join_scan_checker.sv
tb/tb_asof_join_scan.sv
